// ===== hdl/spq_pkg.sv =====
// Shared types and codes for the stable priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

  localparam int unsigned SPQ_CAPACITY = 16;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRI_W  = 8;
  localparam int unsigned FILL_W = 5;

  // command codes carried on in_tuser
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // result status carried on out_tuser
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic   push;  // accepted enqueue, queue not full
    logic   pop;   // accepted dequeue, queue not empty
    entry_t ins;   // entry being inserted
  } ctrl_t;

endpackage

// ===== hdl/stable_priority_queue_unit.sv =====
// Top level of the stable priority queue: cell row, fill count, result register.
// Depends on spq_pkg and spq_cell.
//
// Bounded priority queue kept sorted in a row of CAPACITY cells, highest
// priority at cell 0. Each input transaction is an enqueue (in_tuser = 0) or
// a dequeue (in_tuser = 1) and yields exactly one result transaction. An
// enqueue lands behind every stored entry of greater or equal priority, so
// equal priorities leave in arrival order; all cells compare against the new
// priority at once and the cells behind the insert point shift one place
// back in the same cycle. A dequeue returns cell 0 and shifts the row
// forward. The queue takes one transaction per clock unless a held result
// stalls it; the result is registered and appears in the cycle after the
// transaction is accepted. in_tready stays high while the output register
// is empty or being drained, so back pressure from the result side stalls
// the input only when a result is held. Enqueue on a full queue is dropped
// with status full; dequeue on an empty queue reports empty. fill_level is
// the entry count after the transaction, modulo 32. After reset there is no
// clearing pass: only the fill count and the output valid flag are reset.
module stable_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = SPQ_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] item_id, [23:16] item_priority
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] out_id, [23:16] out_priority,
                                  // [28:24] fill_level, [31:29] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       status_r, status_nxt;
  entry_t        res_r, res_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic   in_fire;
  logic   is_full;
  logic   is_empty;
  ctrl_t  ctrl;
  entry_t cell_q [CAPACITY];
  logic   cell_ge [CAPACITY];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_full   = (count_r == CW'(CAPACITY));
  assign is_empty  = (count_r == '0);

  assign ctrl.push    = in_fire && (in_tuser == CMD_ENQ) && !is_full;
  assign ctrl.pop     = in_fire && (in_tuser == CMD_DEQ) && !is_empty;
  assign ctrl.ins.id  = in_tdata[15:0];
  assign ctrl.ins.pri = in_tdata[23:16];

  // cell row: cell 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   lge;
    entry_t lq;
    entry_t rq;

    assign occ = (count_r > CW'(i));

    if (i == 0) begin : g_first
      assign lge = 1'b1;
      assign lq  = ctrl.ins;
    end else begin : g_mid
      assign lge = cell_ge[i-1];
      assign lq  = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rq = cell_q[i];
    end else begin : g_inner
      assign rq = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .occ     (occ),
      .left_ge (lge),
      .left_q  (lq),
      .right_q (rq),
      .ge      (cell_ge[i]),
      .q       (cell_q[i])
    );
  end

  // fill count and result
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    res_nxt       = res_r;
    fill_nxt      = fill_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      if (in_tuser == CMD_ENQ) begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_ENQ;
          count_nxt  = count_r + CW'(1);
        end
      end else begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt = ST_DEQ;
          res_nxt    = cell_q[0];
          count_nxt  = count_r - CW'(1);
        end
      end
      fill_nxt = FILL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    res_r    <= res_nxt;
    fill_r   <= fill_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, fill_r, res_r.pri, res_r.id};

endmodule

// ===== hdl/spq_cell.sv =====
// One slot of the sorted cell row: holds an entry, compares it with the
// incoming priority and shifts toward its neighbors. Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic   clk,
  input  ctrl_t  ctrl,
  input  logic   occ,       // slot holds a live entry
  input  logic   left_ge,   // left neighbor keeps its place on insert
  input  entry_t left_q,
  input  entry_t right_q,
  output logic   ge,        // this slot keeps its place on insert
  output entry_t q
);

  entry_t q_r;
  entry_t q_nxt;

  // live entry with priority >= new one stays ahead of it
  assign ge = occ && (q_r.pri >= ctrl.ins.pri);
  assign q  = q_r;

  always_comb begin
    q_nxt = q_r;
    if (ctrl.push) begin
      if (!ge) begin
        q_nxt = left_ge ? ctrl.ins : left_q;
      end
    end else if (ctrl.pop) begin
      q_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

// ===== hdl/spq_chk.sv =====
// Port-level checker for the stable priority queue, bound to the top level.
// Depends on spq_pkg.
module spq_chk
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = SPQ_CAPACITY
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result pending");

  // empty report carries no entry and zero fill
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |-> (out_tdata[28:0] == 29'd0))
    else $error("empty result not zero");

  // full report keeps the queue at capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL)
      |-> (out_tdata[23:0] == 24'd0) && (out_tdata[28:24] == FILL_W'(CAPACITY)))
    else $error("full result malformed");

  // accepted enqueue returns no entry
  a_enq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ENQ) |-> (out_tdata[23:0] == 24'd0))
    else $error("enqueue result carries an entry");

endmodule

bind stable_priority_queue_unit spq_chk #(.CAPACITY(CAPACITY)) u_spq_chk (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for stable_priority_queue_unit: directed table, then random traffic.
// Depends on spq_pkg and the block's RTL; keeps its own sorted mirror of the queue.
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int unsigned CAP            = SPQ_CAPACITY;
  localparam int unsigned RANDOM_ITEMS   = 1800;
  localparam int unsigned STALL_MAX      = 12;
  localparam int unsigned PHASE_LEN      = 60;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 8;   // spare cycles after the last owed result
  localparam int unsigned SCRIPT_LEN     = 13;

  typedef struct packed {
    status_t             st;
    logic [ID_W-1:0]     id;
    logic [PRI_W-1:0]    pri;
    logic [FILL_W-1:0]   fill;
  } queue_result_t;

  // One row of the directed table. reps > 1 repeats the request with the id
  // counting up; chk selects a hand-written expectation instead of the mirror.
  typedef struct packed {
    logic                cmd;
    logic [ID_W-1:0]     id;
    logic [PRI_W-1:0]    pri;
    logic [4:0]          reps;
    logic                chk;
    queue_result_t       res;
  } request_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;    // [15:0] item_id, [23:16] item_priority
  logic        in_tuser = 1'b0;  // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [15:0] out_id, [23:16] out_priority, [28:24] fill_level
  logic [1:0]  out_tuser;        // [1:0] status

  // Mirror of the queue contents, kept sorted with the head at index 0.
  logic [ID_W-1:0]  mirror_ids  [CAP];
  logic [PRI_W-1:0] mirror_pris [CAP];
  int unsigned      mirror_count = 0;

  queue_result_t due_results [$];  // results owed by the block, oldest first
  int unsigned   fault_count = 0;
  bit            in_calm = 1'b0;   // sender runs without gaps while set
  bit            out_calm = 1'b0;  // receiver runs without stalls while set

  // Directed table:
  //   dequeue on an empty queue right after reset, extreme ids and priorities,
  //   equal priorities leaving in arrival order, filling to capacity, enqueue
  //   on a full queue being dropped, a new top priority jumping to the head.
  request_row_t opening_requests [SCRIPT_LEN] = '{
    '{CMD_DEQ, 16'h0000, 8'h00, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 8'h00, 5'd0}},
    '{CMD_ENQ, 16'hFFFF, 8'hFF, 5'd1,  1'b1, '{ST_ENQ,   16'h0000, 8'h00, 5'd1}},
    '{CMD_ENQ, 16'h0000, 8'h00, 5'd1,  1'b1, '{ST_ENQ,   16'h0000, 8'h00, 5'd2}},
    '{CMD_ENQ, 16'h0001, 8'h80, 5'd1,  1'b0, '0},
    '{CMD_ENQ, 16'h0002, 8'h80, 5'd1,  1'b0, '0},
    // fields of a dequeue are don't-care; drive them all ones
    '{CMD_DEQ, 16'hFFFF, 8'hFF, 5'd1,  1'b1, '{ST_DEQ,   16'hFFFF, 8'hFF, 5'd3}},
    '{CMD_DEQ, 16'h0000, 8'h00, 5'd1,  1'b0, '0},
    '{CMD_ENQ, 16'h0003, 8'h80, 5'd1,  1'b0, '0},
    // ties at 0x80 until the queue holds CAP entries
    '{CMD_ENQ, 16'h0100, 8'h80, 5'd13, 1'b0, '0},
    '{CMD_ENQ, 16'h5555, 8'hAA, 5'd1,  1'b1, '{ST_FULL,  16'h0000, 8'h00, 5'd16}},
    '{CMD_DEQ, 16'h0000, 8'h00, 5'd1,  1'b0, '0},
    '{CMD_ENQ, 16'h7777, 8'hFF, 5'd1,  1'b0, '0},
    '{CMD_DEQ, 16'h0000, 8'h00, 5'd1,  1'b0, '0}
  };

  stable_priority_queue_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one request to the mirror and returns the result it must give.
  function automatic queue_result_t queue_update(logic cmd, logic [ID_W-1:0] id,
                                                 logic [PRI_W-1:0] pri);
    queue_result_t r;
    int unsigned   pos;
    int unsigned   k;
    r = '0;
    if (cmd == CMD_ENQ) begin
      if (mirror_count >= CAP) begin
        r.st = ST_FULL;
      end else begin
        // land behind every entry of greater or equal priority
        pos = 0;
        while (pos < mirror_count && mirror_pris[pos] >= pri) pos++;
        for (k = mirror_count; k > pos; k--) begin
          mirror_ids[k]  = mirror_ids[k-1];
          mirror_pris[k] = mirror_pris[k-1];
        end
        mirror_ids[pos]  = id;
        mirror_pris[pos] = pri;
        mirror_count++;
        r.st = ST_ENQ;
      end
    end else begin
      if (mirror_count == 0) begin
        r.st = ST_EMPTY;
      end else begin
        r.st  = ST_DEQ;
        r.id  = mirror_ids[0];
        r.pri = mirror_pris[0];
        for (k = 1; k < mirror_count; k++) begin
          mirror_ids[k-1]  = mirror_ids[k];
          mirror_pris[k-1] = mirror_pris[k];
        end
        mirror_count--;
      end
    end
    r.fill = FILL_W'(mirror_count);
    return r;
  endfunction

  // Drives one request transaction after a random gap. in_tvalid is only
  // lowered when a gap follows, so back-to-back transactions keep it high.
  task automatic send_request(logic cmd, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri,
                              bit has_exp, queue_result_t exp_r);
    int unsigned   gap;
    queue_result_t pred;
    gap = in_calm ? 0 : $urandom_range(0, STALL_MAX);
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {pri, id};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    pred = queue_update(cmd, id, pri);
    due_results.push_back(has_exp ? exp_r : pred);
  endtask

  // Stimulus: reset, directed table, random phases, drain.
  initial begin
    int unsigned   n;
    int unsigned   r;
    int unsigned   enq_pct;
    logic          cmd;
    logic [15:0]   id;
    logic [7:0]    pri;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < SCRIPT_LEN; n++) begin
      for (r = 0; r < opening_requests[n].reps; r++) begin
        send_request(opening_requests[n].cmd, opening_requests[n].id + 16'(r),
                     opening_requests[n].pri, opening_requests[n].chk,
                     opening_requests[n].res);
      end
    end

    // Random part in phases biased toward filling, draining or balance, so
    // that both the full and the empty boundary are hit over and over.
    enq_pct = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 85;
          1: enq_pct = 15;
          default: enq_pct = 50;
        endcase
      end
      cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      id  = 16'($urandom_range(0, 65535));
      // half the priorities from a tiny set to force many ties
      if ($urandom_range(0, 1) == 0) pri = 8'($urandom_range(0, 255));
      else pri = 8'($urandom_range(0, 3) * 85);
      send_request(cmd, id, pri, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: random stall before each transaction, then field-by-field
  // compare against the oldest owed result.
  initial begin
    int unsigned   stall;
    queue_result_t want;
    queue_result_t got;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, STALL_MAX);
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      got.st   = status_t'(out_tuser);
      got.id   = out_tdata[15:0];
      got.pri  = out_tdata[23:16];
      got.fill = out_tdata[28:24];
      if (due_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result transaction: status %0d id %h pri %h fill %0d",
                   got.st, got.id, got.pri, got.fill);
      end else begin
        want = due_results.pop_front();
        if (got.st !== want.st || got.id !== want.id || got.pri !== want.pri ||
            got.fill !== want.fill) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: expected status %0d id %h pri %h fill %0d",
                     want.st, want.id, want.pri, want.fill);
            $display("          got      status %0d id %h pri %h fill %0d",
                     got.st, got.id, got.pri, got.fill);
          end
        end
      end
    end
  end

  // Watchdog: too many cycles without any transaction on either side.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
        (out_tvalid === 1'b1 && out_tready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

// ===== files.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue_unit.sv
hdl/spq_chk.sv
tb/testbench.sv
